/* sv/lcf_pkg.sv */
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types and constants of the linear convolution FIR.
// ----------------------------------------------------------------------------
`default_nettype none

package lcf_pkg;

    localparam int SMP_W  = 16;
    localparam int PROD_W = 32;
    localparam int RES_W  = 40;
    localparam int CNT_W  = 7;
    localparam int IDX_W  = 6;

    localparam logic [CNT_W-1:0] TAP_COUNT_RST = 7'd32;

    localparam logic KIND_TAP    = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    typedef struct packed {
        logic clr;
        logic mul_en;
    } t_mac_ctl;

endpackage

`default_nettype wire

/* sv/lcf_ifs.sv */
// ----------------------------------------------------------------------------
// lcf_ifs
// Channel interfaces: input items, result items and the tap_count write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcf_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [5:0]  tap_index;
    logic signed [15:0] value;
    logic        last_sample;

    modport source (output valid, kind, tap_index, value, last_sample, input ready);
    modport sink   (input valid, kind, tap_index, value, last_sample, output ready);
endinterface

interface lcf_out_if;
    logic        valid;
    logic        ready;
    logic signed [39:0] result;
    logic        last;

    modport source (output valid, result, last, input ready);
    modport sink   (input valid, result, last, output ready);
endinterface

interface lcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [6:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* sv/lcf_mac.sv */
// ----------------------------------------------------------------------------
// lcf_mac
// Shared multiply-accumulate: registered 16x16 product, 40-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lcf_mac
    import lcf_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [SMP_W-1:0]  i_a,
    input  wire logic signed [SMP_W-1:0]  i_b,
    output logic signed [RES_W-1:0]       o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [RES_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else if (i_ctl.clr) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.mul_en;
            if (r_pv) begin
                r_acc <= r_acc + {{(RES_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            end
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

/* sv/linear_convolution_fir.sv */
// ----------------------------------------------------------------------------
// linear_convolution_fir
// Direct-form FIR giving the full linear convolution of a sample stream.
// ----------------------------------------------------------------------------
// i_smp carries tap writes (kind 0: value to tap tap_index) and samples
// (kind 1). A tap write gives no result. A sample shifts the delay line and
// gives one result on o_res; a sample with last_sample set then gives n-1
// tail results, n being tap_count clamped to 1..NUM_TAPS, flushing zeros,
// and clears the delay line. The last result of each sample beat carries last.
// After acceptance each result runs through NUM_TAPS product steps, a drain
// step and a load step that waits while the output register is full, tail
// results included; i_smp is ready again after the sample's last load.
// The tap ring and delay ring rotate once per result through the single
// shared multiplier, one product per cycle in the product steps. i_smp is
// not ready while a sample is in work. i_cfg writes tap_count (always ready);
// write it only while idle.
// Results sit in an output register; a stall on o_res holds the next result
// in the accumulator until the register frees.
// Reset clears taps and delay line and sets tap_count to 32; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_convolution_fir
    import lcf_pkg::*;
#(
    parameter int NUM_TAPS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lcf_in_if.sink     i_smp,
    lcf_cfg_if.sink    i_cfg,
    lcf_out_if.source  o_res
);

    localparam int KW = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MAC    = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_RESULT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic signed [SMP_W-1:0] r_tap [NUM_TAPS];
    logic signed [SMP_W-1:0] r_dly [NUM_TAPS];
    logic [CNT_W-1:0]        r_tap_count;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_remain;
    logic                    r_tail;
    logic [KW-1:0]           r_k;
    logic                    r_out_valid;
    logic signed [RES_W-1:0] r_result;
    logic                    r_last;

    logic                    w_acc_smp;
    logic                    w_out_free;
    logic                    w_load;
    logic                    w_more;
    logic [CNT_W-1:0]        w_n;
    t_mac_ctl                w_ctl;
    logic signed [RES_W-1:0] w_acc;

    assign i_smp.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_acc_smp   = i_smp.valid && i_smp.ready && (i_smp.kind == KIND_SAMPLE);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_load      = (r_state == S_RESULT) && w_out_free;
    assign w_more      = r_tail && (r_remain != '0);

    always_comb begin
        if (r_tap_count == '0) begin
            w_n = CNT_W'(1);
        end else if (r_tap_count > CNT_W'(NUM_TAPS)) begin
            w_n = CNT_W'(NUM_TAPS);
        end else begin
            w_n = r_tap_count;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_acc_smp) n_state = S_MAC;
            end
            S_MAC: begin
                if (r_k == KW'(NUM_TAPS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (w_out_free) n_state = w_more ? S_MAC : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ctl.clr    = w_acc_smp || (w_load && w_more);
        w_ctl.mul_en = (r_state == S_MAC) && (CNT_W'(r_k) < r_n);
    end

    lcf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (r_tap[0]),
        .i_b     (r_dly[0]),
        .o_acc   (w_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= TAP_COUNT_RST;
            r_n         <= CNT_W'(1);
            r_remain    <= '0;
            r_tail      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < NUM_TAPS; j++) begin
                r_tap[j] <= '0;
                r_dly[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                r_tap_count <= i_cfg.data;
            end
            if (i_smp.valid && i_smp.ready && (i_smp.kind == KIND_TAP)) begin
                for (int j = 0; j < NUM_TAPS; j++) begin
                    if (i_smp.tap_index == IDX_W'(j)) r_tap[j] <= i_smp.value;
                end
            end
            if (w_acc_smp) begin
                for (int j = NUM_TAPS - 1; j > 0; j--) r_dly[j] <= r_dly[j-1];
                r_dly[0] <= i_smp.value;
                r_n      <= w_n;
                r_remain <= w_n - CNT_W'(1);
                r_tail   <= i_smp.last_sample;
                r_k      <= '0;
            end
            // rotate both rings once per result; they end where they started
            if (r_state == S_MAC) begin
                for (int j = 0; j < NUM_TAPS; j++) begin
                    r_tap[j] <= r_tap[(j + 1) % NUM_TAPS];
                    r_dly[j] <= r_dly[(j + 1) % NUM_TAPS];
                end
                r_k <= r_k + KW'(1);
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (w_more) begin
                    for (int j = NUM_TAPS - 1; j > 0; j--) r_dly[j] <= r_dly[j-1];
                    r_dly[0] <= '0;
                    r_remain <= r_remain - CNT_W'(1);
                    r_k      <= '0;
                end else if (r_tail) begin
                    for (int j = 0; j < NUM_TAPS; j++) r_dly[j] <= '0;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_result <= w_acc;
            r_last   <= !w_more;
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.result = r_result;
    assign o_res.last   = r_last;

endmodule

`default_nettype wire

/* dv/tb_linear_convolution_fir.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_convolution_fir
// Self-checking bench for the direct-form linear convolution FIR. A queue of
// tap writes and sample signals feeds a clocked driver. A shadow tap store
// and delay line predict every convolution output, including the tail that a
// final sample flushes. A clocked monitor compares each output beat with the
// oldest prediction. Both channels stall in random bursts, and one long
// receiver stall backs the block up. tap_count is rewritten between phases,
// extremes included.
// ----------------------------------------------------------------------------

module tb_linear_convolution_fir;
    import lcf_pkg::*;

    localparam int NUM_TAPS = 32;
    localparam int LIMIT    = 2_000_000;
    localparam int CHOKE    = 600;

    typedef struct {
        logic                    kind;
        logic [IDX_W-1:0]        tap_index;
        logic signed [SMP_W-1:0] value;
        logic                    last_sample;
    } t_smp_beat;

    typedef struct {
        logic signed [RES_W-1:0] result;
        logic                    last;
    } t_res_beat;

    logic i_clk;
    logic i_rst_n;

    lcf_in_if  smp_if ();
    lcf_cfg_if cfg_if ();
    lcf_out_if res_if ();

    linear_convolution_fir #(.NUM_TAPS(NUM_TAPS)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    t_smp_beat beat_q[$];
    t_res_beat conv_due[$];
    t_smp_beat cur_beat;
    t_res_beat due_head;

    logic signed [SMP_W-1:0] tap_mem  [NUM_TAPS];
    logic signed [SMP_W-1:0] line_mem [NUM_TAPS];
    logic [CNT_W-1:0]        tap_count_q;

    int err_cnt = 0;
    int cyc = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int choke_left = 0;
    bit choke_done = 0;
    bit choke_phase = 0;
    bit calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [RES_W-1:0] tap_dot(input int n);
        logic signed [RES_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < n; k++) begin
            acc = acc + tap_mem[k] * line_mem[k];
        end
        return acc;
    endfunction

    function automatic void shift_line(input logic signed [SMP_W-1:0] s);
        for (int k = NUM_TAPS - 1; k > 0; k--) begin
            line_mem[k] = line_mem[k-1];
        end
        line_mem[0] = s;
    endfunction

    // predict the outputs of one accepted input beat
    function automatic void absorb_beat(input t_smp_beat b);
        int n;
        if (b.kind == KIND_TAP) begin
            if (int'(b.tap_index) < NUM_TAPS) begin
                tap_mem[b.tap_index] = b.value;
            end
            return;
        end
        n = int'(tap_count_q);
        if (n < 1) begin
            n = 1;
        end
        if (n > NUM_TAPS) begin
            n = NUM_TAPS;
        end
        shift_line(b.value);
        conv_due.push_back('{tap_dot(n), !(b.last_sample && n > 1)});
        if (b.last_sample) begin
            for (int t = 1; t < n; t++) begin
                shift_line('0);
                conv_due.push_back('{tap_dot(n), t == n - 1});
            end
            for (int k = 0; k < NUM_TAPS; k++) begin
                line_mem[k] = '0;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (smp_if.valid && smp_if.ready) begin
                absorb_beat(cur_beat);
            end
            if (!smp_if.valid || smp_if.ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    smp_if.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 9);
                    smp_if.valid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    cur_beat = beat_q.pop_front();
                    smp_if.valid       <= 1'b1;
                    smp_if.kind        <= cur_beat.kind;
                    smp_if.tap_index   <= cur_beat.tap_index;
                    smp_if.value       <= cur_beat.value;
                    smp_if.last_sample <= cur_beat.last_sample;
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // hold off the receiver once for a long stretch
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (choke_left != 0) begin
                choke_left <= choke_left - 1;
            end else if (choke_phase && !choke_done && res_if.valid) begin
                choke_left <= CHOKE;
                choke_done <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (conv_due.size() == 0) begin
                    $error("unexpected beat: result %0d last %0b", res_if.result, res_if.last);
                    err_cnt++;
                end else begin
                    due_head = conv_due.pop_front();
                    if (res_if.result !== due_head.result) begin
                        $error("result: expected %0d, got %0d", due_head.result, res_if.result);
                        err_cnt++;
                    end
                    if (res_if.last !== due_head.last) begin
                        $error("last: expected %0b, got %0b", due_head.last, res_if.last);
                        err_cnt++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                res_if.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(0, 9);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= (choke_left == 0);
            end
        end
    end

    function automatic logic signed [SMP_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic void queue_beat(input logic kind, input logic [IDX_W-1:0] idx,
                                       input logic signed [SMP_W-1:0] v, input logic last);
        beat_q.push_back('{kind, idx, v, last});
    endfunction

    task automatic wait_idle();
        while (beat_q.size() != 0 || smp_if.valid || conv_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * NUM_TAPS) @(posedge i_clk);
    endtask

    task automatic write_tap_count(input logic [CNT_W-1:0] cnt);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= cnt;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        tap_count_q = cnt;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] cnt, input int extra);
        int eff;
        int made;
        int len;
        eff = (cnt < 1) ? 1 : ((cnt > NUM_TAPS) ? NUM_TAPS : int'(cnt));
        wait_idle();
        write_tap_count(cnt);
        for (int j = 0; j < eff; j++) begin
            queue_beat(KIND_TAP, IDX_W'(j), pick_value(), 1'($urandom));
        end
        made = 0;
        while (made < extra) begin
            if ($urandom_range(0, 9) < 7) begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++) begin
                    queue_beat(KIND_SAMPLE, IDX_W'($urandom), pick_value(), j == len - 1);
                end
                made += len;
            end else if ($urandom_range(0, 1) == 0) begin
                queue_beat(KIND_TAP, IDX_W'($urandom), pick_value(), 1'($urandom));
                made++;
            end else begin
                queue_beat(KIND_SAMPLE, IDX_W'($urandom), pick_value(), 1'($urandom));
                made++;
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        smp_if.valid       = 1'b0;
        smp_if.kind        = KIND_TAP;
        smp_if.tap_index   = '0;
        smp_if.value       = '0;
        smp_if.last_sample = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;
        tap_count_q        = TAP_COUNT_RST;
        for (int k = 0; k < NUM_TAPS; k++) begin
            tap_mem[k]  = '0;
            line_mem[k] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_beat(KIND_SAMPLE, 6'd63, 16'sd12345, 1'b0);
        queue_beat(KIND_TAP, 6'd0, 16'sh7fff, 1'b0);
        queue_beat(KIND_TAP, 6'd31, 16'sh8000, 1'b0);
        queue_beat(KIND_TAP, 6'd1, -16'sd1, 1'b0);
        queue_beat(KIND_TAP, 6'd32, 16'sd1000, 1'b0);
        queue_beat(KIND_TAP, 6'd63, 16'sh8000, 1'b1);
        queue_beat(KIND_TAP, 6'd15, 16'sh5a5a, 1'b1);
        queue_beat(KIND_SAMPLE, 6'd0, 16'sh8000, 1'b0);
        queue_beat(KIND_SAMPLE, 6'd21, 16'sh7fff, 1'b0);
        queue_beat(KIND_SAMPLE, 6'd42, 16'sh8000, 1'b1);
        queue_beat(KIND_SAMPLE, 6'd0, 16'sh7fff, 1'b1);
        queue_beat(KIND_SAMPLE, 6'd42, 16'sh0000, 1'b0);
        queue_beat(KIND_SAMPLE, 6'd7, -16'sd1, 1'b1);

        run_phase(7'd1, 15);
        run_phase(7'd0, 15);
        run_phase(7'd127, 15);
        wait_idle();
        choke_phase = 1'b1;
        run_phase(7'd4, 30);
        run_phase(7'd64, 15);
        run_phase(7'd9, 15);
        run_phase(7'd2, 15);
        run_phase(7'd33, 15);
        run_phase(7'd16, 15);
        run_phase(7'd5, 15);
        run_phase(7'd3, 15);
        wait_idle();
        calm = 1'b1;
        run_phase(7'd32, 20);
        wait_idle();

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
